// File: rtl/core/vwd_pkg.sv
// vwd_pkg: shared types and constants for the vertex weld block.
// Used by vwd_ctrl, vwd_dpath and vertex_weld_dedup_top.
`default_nettype none
package vwd_pkg;
   localparam int TABLE_SLOTS_DEF = 1024;
   localparam int COORD_FRAC_DEF  = 16;
   localparam int INV_FRAC_BITS   = 16;
   localparam int INDEX_LIMIT     = 1024;
   localparam logic [23:0] MERGE_MAX = 24'hFFFFFF;
   localparam logic [31:0] INV_TOL_RESET = 32'h0001_0000;
   localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_MUL, ST_QUANT, ST_HASH1, ST_HASH2,
      ST_READ, ST_CHECK, ST_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic clear_step;
      logic mul;
      logic quant;
      logic hash1;
      logic hash2;
      logic read;
      logic check;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_done;
      logic start_new;
      logic probe_done;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/core/vwd_ctrl.sv
// vwd_ctrl: sequencer for the weld block (clear sweep, multiply, quantize, hash, probe).
// Depends on vwd_pkg.
`default_nettype none
module vwd_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   input  wire vwd_pkg::sts_type sts,
   output vwd_pkg::cmd_type cmd
);
   vwd_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // hold state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vwd_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         vwd_pkg::ST_IDLE: begin
            req_stall = rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               cmd.load = 1'b1;
               state_in = vwd_pkg::ST_MUL;
            end
         end
         vwd_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done)
               state_in = sts.start_new ? vwd_pkg::ST_QUANT : vwd_pkg::ST_IDLE;
         end
         vwd_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sts.start_new ? vwd_pkg::ST_CLEAR : vwd_pkg::ST_QUANT;
         end
         vwd_pkg::ST_QUANT: begin
            cmd.quant = 1'b1;
            state_in  = vwd_pkg::ST_HASH1;
         end
         vwd_pkg::ST_HASH1: begin
            cmd.hash1 = 1'b1;
            state_in  = vwd_pkg::ST_HASH2;
         end
         vwd_pkg::ST_HASH2: begin
            cmd.hash2 = 1'b1;
            state_in  = vwd_pkg::ST_READ;
         end
         vwd_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = vwd_pkg::ST_CHECK;
         end
         vwd_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.probe_done ? vwd_pkg::ST_OUT : vwd_pkg::ST_READ;
         end
         vwd_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = vwd_pkg::ST_IDLE;
         end
         default: state_in = vwd_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: rtl/core/vwd_dpath.sv
// vwd_dpath: quantizers, hash, slot tables and counters of the weld block.
// Depends on vwd_pkg.
`default_nettype none
module vwd_dpath #(
   parameter int TABLE_SLOTS     = vwd_pkg::TABLE_SLOTS_DEF,
   parameter int COORD_FRAC_BITS = vwd_pkg::COORD_FRAC_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire vwd_pkg::cmd_type cmd,
   output vwd_pkg::sts_type sts,
   input  wire logic [31:0] inv_tol,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic        req_start_new,
   output logic [9:0]       rsp_canonical_index,
   output logic             rsp_is_new,
   output logic             rsp_table_full,
   output logic [23:0]      rsp_merged_count
);
   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int SH = COORD_FRAC_BITS + vwd_pkg::INV_FRAC_BITS;

   // slot memories; valid bits are a memory too, swept clear
   logic [95:0] key_mem [TABLE_SLOTS];
   logic [9:0]  idx_mem [TABLE_SLOTS];
   logic        vld_mem [TABLE_SLOTS];

   logic [31:0] mag_ff [3];
   logic        neg_ff [3];
   logic [63:0] prod_ff [3];
   logic [31:0] key_ff [3];
   logic        start_ff;
   logic [63:0] h_ff;
   logic [AW-1:0] slot_ff, clr_ff;
   logic [AW:0]   probes_ff;
   logic [95:0] rd_key_ff;
   logic [9:0]  rd_idx_ff;
   logic        rd_vld_ff;
   logic [10:0] distinct_ff;
   logic [23:0] merged_ff;
   logic [9:0]  oidx_ff;
   logic        onew_ff, ofull_ff;

   logic [95:0] key_cat;
   logic        do_clear, do_write;
   logic [63:0] kx, ky, kz, h1, h2;
   logic        match, empty;

   assign key_cat  = {key_ff[2], key_ff[1], key_ff[0]};
   assign match    = rd_vld_ff && (rd_key_ff == key_cat);
   assign empty    = !rd_vld_ff;
   assign do_write = cmd.check && empty && (distinct_ff < 11'(vwd_pkg::INDEX_LIMIT));
   assign do_clear = cmd.clear_step;

   // hash combining steps
   assign kx = {{32{key_ff[0][31]}}, key_ff[0]};
   assign ky = {{32{key_ff[1][31]}}, key_ff[1]};
   assign kz = {{32{key_ff[2][31]}}, key_ff[2]};
   assign h1 = kx ^ (ky + vwd_pkg::HASH_GOLDEN + (kx << 6) + (kx >> 2));
   assign h2 = h_ff ^ (kz + vwd_pkg::HASH_GOLDEN + (h_ff << 6) + (h_ff >> 2));

   // memory write and read
   always_ff @(posedge clock) begin
      if (do_clear) vld_mem[clr_ff] <= 1'b0;
      else if (do_write) begin
         vld_mem[slot_ff] <= 1'b1;
         key_mem[slot_ff] <= key_cat;
         idx_mem[slot_ff] <= distinct_ff[9:0];
      end
      if (cmd.read) begin
         rd_vld_ff <= vld_mem[slot_ff];
         rd_key_ff <= key_mem[slot_ff];
         rd_idx_ff <= idx_mem[slot_ff];
      end
   end

   function automatic logic [31:0] quant(input logic [63:0] p, input logic n);
      logic [64:0] r;
      r = ({1'b0, p} + (65'd1 << (SH - 1))) >> SH;
      if (n) begin
         if (r > 65'h80000000) r = 65'h80000000;
         quant = 32'(-r[31:0]);
      end else begin
         if (r > 65'h7FFFFFFF) r = 65'h7FFFFFFF;
         quant = r[31:0];
      end
   endfunction

   // payload pipeline: magnitude, multiply, round and saturate, hash
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff[0] <= req_coord_x[31] ? 32'(-req_coord_x) : req_coord_x;
         mag_ff[1] <= req_coord_y[31] ? 32'(-req_coord_y) : req_coord_y;
         mag_ff[2] <= req_coord_z[31] ? 32'(-req_coord_z) : req_coord_z;
         neg_ff[0] <= req_coord_x[31];
         neg_ff[1] <= req_coord_y[31];
         neg_ff[2] <= req_coord_z[31];
      end
      if (cmd.mul)
         for (int i = 0; i < 3; i++) prod_ff[i] <= 64'(mag_ff[i]) * 64'(inv_tol);
      if (cmd.quant)
         for (int i = 0; i < 3; i++) key_ff[i] <= quant(prod_ff[i], neg_ff[i]);
      if (cmd.hash1) h_ff <= h1;
      if (cmd.hash2) slot_ff <= h2[AW-1:0];
      else if (cmd.check && !match && !empty) slot_ff <= slot_ff + 1'b1;
   end

   // control registers: sweep pointer, probe count, counters, result
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         start_ff    <= 1'b0;
         probes_ff   <= '0;
         distinct_ff <= '0;
         merged_ff   <= '0;
         oidx_ff     <= '0;
         onew_ff     <= 1'b0;
         ofull_ff    <= 1'b0;
      end else begin
         if (cmd.load) start_ff <= req_start_new;
         if (do_clear) begin
            clr_ff <= clr_ff + 1'b1;
            distinct_ff <= '0;
            merged_ff   <= '0;
         end
         if (cmd.hash2) probes_ff <= '0;
         if (cmd.check) begin
            probes_ff <= probes_ff + 1'b1;
            oidx_ff  <= '0;
            onew_ff  <= 1'b0;
            ofull_ff <= 1'b0;
            if (match) begin
               oidx_ff <= rd_idx_ff;
               if (merged_ff != vwd_pkg::MERGE_MAX) merged_ff <= merged_ff + 1'b1;
            end else if (do_write) begin
               oidx_ff     <= distinct_ff[9:0];
               onew_ff     <= 1'b1;
               distinct_ff <= distinct_ff + 1'b1;
            end else if (empty || probes_ff == (AW+1)'(TABLE_SLOTS - 1)) begin
               ofull_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.clear_done = do_clear && (clr_ff == AW'(TABLE_SLOTS - 1));
   assign sts.start_new  = start_ff;
   assign sts.probe_done = match || empty || (probes_ff == (AW+1)'(TABLE_SLOTS - 1));

   assign rsp_canonical_index = oidx_ff;
   assign rsp_is_new          = onew_ff;
   assign rsp_table_full      = ofull_ff;
   assign rsp_merged_count    = merged_ff;
endmodule
`default_nettype wire

// File: rtl/core/vertex_weld_dedup_top.sv
// vertex_weld_dedup_top: vertex welding by spatial hash, top level.
// Depends on vwd_pkg, vwd_ctrl, vwd_dpath.
//
//  channel  ports                                   direction
//  req      req_valid/req_stall, coords, start_new  in
//  rsp      rsp_valid/rsp_stall, index, flags, count out
//  csr      csr_wr_en/csr_wr_data (inv_tolerance)   in
//
// Each vertex is loaded, multiplied, quantized and hashed in two steps, then
// probes slots (one registered memory read and one compare per probe).
// After reset, and on start_new, a sweep over all TABLE_SLOTS slots clears the
// occupancy bits; no vertex is accepted during the reset sweep.
// The result register holds while rsp_stall is high; no new vertex is taken
// until it transfers.
`default_nettype none
module vertex_weld_dedup_top #(
   parameter int TABLE_SLOTS     = vwd_pkg::TABLE_SLOTS_DEF,
   parameter int COORD_FRAC_BITS = vwd_pkg::COORD_FRAC_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   input  wire logic        req_start_new,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [9:0]       rsp_canonical_index,
   output logic             rsp_is_new,
   output logic             rsp_table_full,
   output logic [23:0]      rsp_merged_count,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   vwd_pkg::cmd_type cmd;
   vwd_pkg::sts_type sts;
   logic [31:0] inv_tol_ff;

   // hold the tolerance register
   always_ff @(posedge clock) begin
      if (reset) inv_tol_ff <= vwd_pkg::INV_TOL_RESET;
      else if (csr_wr_en) inv_tol_ff <= csr_wr_data;
   end

   vwd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   vwd_dpath #(.TABLE_SLOTS(TABLE_SLOTS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dpath (
      .clock, .reset, .cmd, .sts, .inv_tol(inv_tol_ff),
      .req_coord_x, .req_coord_y, .req_coord_z, .req_start_new,
      .rsp_canonical_index, .rsp_is_new, .rsp_table_full, .rsp_merged_count
   );

   // a new result never carries both flags
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_new && rsp_table_full)) else $error("new and full");
   // a full result reports index zero
   a_full_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> rsp_canonical_index == '0)
      else $error("full index");
   // no vertex taken while a result waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("overlap");
endmodule
`default_nettype wire
